// File: rtl/tts_pkg.sv
// tts_pkg: constants, types and helpers for the text terminal block
// depends on nothing; used by the interfaces, the screen ram and the top level
package tts_pkg;

    // screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int AW        = RW + CW;
    localparam int MEM_DEPTH = ROWS * (1 << CW);

    // request and response field widths
    localparam int FUNC_W = 1;
    localparam int CHAR_W = 8;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;
    localparam int CELL_W = 16;
    localparam int CROW_W = 5;
    localparam int CCOL_W = 7;
    localparam int ATTR_W = 8;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // reset values
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

    typedef logic [RW-1:0]     t_row;
    typedef logic [CW-1:0]     t_col;
    typedef logic [AW-1:0]     t_addr;
    typedef logic [CELL_W-1:0] t_cell;

    // one write into the screen store
    typedef struct packed {
        logic  en;
        t_addr addr;
        t_cell data;
    } t_ram_wr;

    // map a screen row to its row in the store, rows rotate by the base row
    function automatic t_row phys_row(input t_row lrow, input t_row base);
        logic [RW:0] s;
        s = {1'b0, lrow} + {1'b0, base};
        if (s >= (RW+1)'(ROWS)) begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

endpackage

// File: rtl/tts_if.sv
// tts_if: valid/ready channel interfaces for requests, responses and configuration
// depends on tts_pkg for field widths
interface tts_req_if;
    import tts_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (output valid, func, char_code, read_row, read_col, input ready);
    modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

interface tts_rsp_if;
    import tts_pkg::*;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_value;
    logic [CROW_W-1:0] cursor_row;
    logic [CCOL_W-1:0] cursor_col;
    logic              scrolled;

    modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, input ready);
    modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, output ready);
endinterface

interface tts_cfg_if;
    import tts_pkg::*;
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/tts_screen_ram.sv
// tts_screen_ram: screen cell store, one write port and one registered read port
// depends on tts_pkg
module tts_screen_ram
    import tts_pkg::*;
(
    input  logic    i_clk,
    input  t_ram_wr i_wr,
    input  t_addr   i_rd_addr,
    output t_cell   o_rd_data
);

    t_cell r_mem [MEM_DEPTH];
    t_cell r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/text_terminal_cursor_scroll.sv
// text_terminal_cursor_scroll: 80x25 character terminal with cursor and scroll
// depends on tts_pkg, tts_if and tts_screen_ram
// put request: response registered at the accepting edge; a scroll adds a row
//   blanking pass over the COLUMNS (80) cells of the row on the shared sweep
//   counter before the next request is taken
// read request: answered through the registered read port of the screen ram and then the response registers
// reset: i_rst_n synchronous active low; then a clearing pass over all ROWS*COLUMNS
//   (2000) cells writes every cell to attribute 7 space, no requests meanwhile
module text_terminal_cursor_scroll
    import tts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    tts_req_if.sink   i_req,
    tts_rsp_if.source o_rsp,
    tts_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_BLANK = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_row   r_row, n_row;
    t_col   r_col, n_col;
    t_row   r_base, n_base;
    t_row   r_sweep_row, n_sweep_row;
    t_col   r_sweep_col, n_sweep_col;
    logic   r_rd_ok, n_rd_ok;
    logic [ATTR_W-1:0] r_attr;

    logic              r_ovalid, n_ovalid;
    logic [CELL_W-1:0] r_o_cell, n_o_cell;
    logic [CROW_W-1:0] r_o_row, n_o_row;
    logic [CCOL_W-1:0] r_o_col, n_o_col;
    logic              r_o_scr, n_o_scr;

    t_ram_wr ram_wr;
    t_addr   ram_rd_addr;
    t_cell   ram_rd_data;

    logic    req_fire;
    logic    rsp_fire;
    logic    sweep_last_col;

    // put request decode
    t_row    p_row;
    t_col    p_col;
    logic    p_wr_en;
    t_row    p_wr_row;
    t_col    p_wr_col;
    t_cell   p_wr_data;
    logic    p_scroll;

    tts_screen_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // handshakes
    assign i_req.ready = (r_state == ST_IDLE) && (!r_ovalid || o_rsp.ready);
    assign req_fire    = i_req.valid && i_req.ready;
    assign rsp_fire    = r_ovalid && o_rsp.ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.cell_value = r_o_cell;
    assign o_rsp.cursor_row = r_o_row;
    assign o_rsp.cursor_col = r_o_col;
    assign o_rsp.scrolled   = r_o_scr;

    // read address from the request, in store coordinates
    assign ram_rd_addr = {phys_row(RW'(i_req.read_row), r_base), CW'(i_req.read_col)};

    assign sweep_last_col = (r_sweep_col == CW'(COLUMNS - 1));

    // cursor movement and cell write for a put request
    always_comb begin
        p_row     = r_row;
        p_col     = r_col;
        p_wr_en   = 1'b0;
        p_wr_row  = r_row;
        p_wr_col  = r_col;
        p_wr_data = {r_attr, i_req.char_code};
        p_scroll  = 1'b0;
        case (i_req.char_code)
            CH_NEWLINE: begin
                p_col = '0;
                if (r_row == RW'(ROWS - 1)) begin
                    p_scroll = 1'b1;
                end else begin
                    p_row = r_row + 1'b1;
                end
            end
            CH_RETURN: begin
                p_col = '0;
            end
            CH_BACKSPACE: begin
                if (r_row != '0 || r_col != '0) begin
                    if (r_col == '0) begin
                        p_row = r_row - 1'b1;
                        p_col = CW'(COLUMNS - 1);
                    end else begin
                        p_col = r_col - 1'b1;
                    end
                    p_wr_en   = 1'b1;
                    p_wr_row  = p_row;
                    p_wr_col  = p_col;
                    p_wr_data = {r_attr, CH_SPACE};
                end
            end
            default: begin
                p_wr_en = 1'b1;
                if (r_col == CW'(COLUMNS - 1)) begin
                    p_col = '0;
                    if (r_row == RW'(ROWS - 1)) begin
                        p_scroll = 1'b1;
                    end else begin
                        p_row = r_row + 1'b1;
                    end
                end else begin
                    p_col = r_col + 1'b1;
                end
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_sweep_row = r_sweep_row;
        n_sweep_col = r_sweep_col;
        n_rd_ok     = r_rd_ok;
        n_ovalid    = r_ovalid && !rsp_fire;
        n_o_cell    = r_o_cell;
        n_o_row     = r_o_row;
        n_o_col     = r_o_col;
        n_o_scr     = r_o_scr;
        ram_wr      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = {r_sweep_row, r_sweep_col};
                ram_wr.data = CELL_RESET;
                n_sweep_col = sweep_last_col ? '0 : r_sweep_col + 1'b1;
                if (sweep_last_col) begin
                    n_sweep_row = r_sweep_row + 1'b1;
                    if (r_sweep_row == RW'(ROWS - 1)) begin
                        n_sweep_row = '0;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.func == FUNC_READ) begin
                        n_rd_ok = (32'(i_req.read_row) < 32'(ROWS))
                               && (32'(i_req.read_col) < 32'(COLUMNS));
                        n_state = ST_READ;
                    end else begin
                        ram_wr.en   = p_wr_en;
                        ram_wr.addr = {phys_row(p_wr_row, r_base), p_wr_col};
                        ram_wr.data = p_wr_data;
                        n_row       = p_row;
                        n_col       = p_col;
                        n_ovalid    = 1'b1;
                        n_o_cell    = '0;
                        n_o_row     = CROW_W'(p_row);
                        n_o_col     = CCOL_W'(p_col);
                        n_o_scr     = p_scroll;
                        if (p_scroll) begin
                            // old top row becomes the new bottom row
                            n_sweep_row = r_base;
                            n_sweep_col = '0;
                            n_base      = (r_base == RW'(ROWS - 1)) ? '0 : r_base + 1'b1;
                            n_state     = ST_BLANK;
                        end
                    end
                end
            end
            ST_READ: begin
                n_ovalid = 1'b1;
                n_o_cell = r_rd_ok ? ram_rd_data : '0;
                n_o_row  = CROW_W'(r_row);
                n_o_col  = CCOL_W'(r_col);
                n_o_scr  = 1'b0;
                n_state  = ST_IDLE;
            end
            ST_BLANK: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = {r_sweep_row, r_sweep_col};
                ram_wr.data = {r_attr, CH_SPACE};
                n_sweep_col = sweep_last_col ? '0 : r_sweep_col + 1'b1;
                if (sweep_last_col) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_sweep_row <= '0;
            r_sweep_col <= '0;
            r_ovalid    <= 1'b0;
            r_attr      <= ATTR_RESET;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_sweep_row <= n_sweep_row;
            r_sweep_col <= n_sweep_col;
            r_ovalid    <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_attr <= i_cfg.data;
            end
        end
    end

    // response payload and read flag
    always_ff @(posedge i_clk) begin
        r_rd_ok  <= n_rd_ok;
        r_o_cell <= n_o_cell;
        r_o_row  <= n_o_row;
        r_o_col  <= n_o_col;
        r_o_scr  <= n_o_scr;
    end

endmodule
